/* rtl/gas_pkg.sv */
// Shared types, constants and command/status structs of the activity selection core.
package gas_pkg;

   localparam int MAX_ACTIVITIES_DEF = 32;
   localparam int TIME_W             = 16;
   localparam int OUT_W              = 6;

   typedef struct packed {
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] finish_time;
   } entry_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_CHK,
      ST_SORT_RD,
      ST_SORT_CAP,
      ST_SCAN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_PICK_RD,
      ST_PICK_CHK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;        // take one input beat into the store
      logic sort_init;   // restart the sort at position zero
      logic sort_rd;     // read the entry at the current sort position
      logic sort_cap;    // capture that entry as position entry and running best
      logic scan_step;   // issue the next scan read and compare the last one
      logic swap_a;      // write best entry to the sort position
      logic swap_b;      // write position entry to the best slot, advance position
      logic pick_init;   // restart the greedy pass
      logic pick_rd;     // read the entry under the pick index
      logic pick_skip;   // advance the pick index without a pick
      logic pick_take;   // take the entry as a pick, push the held pick out
      logic flush;       // push the held pick out as the final pick
      logic clear_set;   // drop count and overflow flag for the next set
   } cmd_type;

   typedef struct packed {
      logic more_sort;   // another sort position remains
      logic scan_done;   // scan reads issued and compared
      logic qualifies;   // entry under the pick index is compatible
      logic pend_valid;  // a pick is held waiting for its successor
      logic out_free;    // output register can load this cycle
      logic last_j;      // pick index is on the final stored entry
   } status_type;

endpackage

/* rtl/greedy_activity_selection_core.sv */
// Top level of the greedy activity selection core.
// The core collects activities, one request beat per cycle, into a single-port
// memory of MAX_ACTIVITIES entries; beats that find the memory full are dropped
// and flag overflow. The beat marked last closes the set (and is itself dropped
// if the memory is full). The core then sorts the stored entries by finish time
// with a selection sort that walks the memory one read per cycle: each sort
// position steps through check, read, capture, its scan, compare of the final
// scan read, scan done and a swap in two writes through the one write port.
// The greedy pass then reads and checks each sorted entry in turn and returns
// one response beat per pick in sorted order; a final flush step pushes out
// the final pick, which carries last_pick. Requests stall from the closing
// beat until the last pick sits in the response register, and a stalled
// response holds the pick pass. The memory needs no clearing: only entries
// written in the current set are read.
module greedy_activity_selection_core #(
   parameter int MAX_ACTIVITIES = gas_pkg::MAX_ACTIVITIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [gas_pkg::TIME_W-1:0]  req_start_time,
   input  logic [gas_pkg::TIME_W-1:0]  req_finish_time,
   input  logic                        req_is_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [gas_pkg::OUT_W-1:0]   rsp_sorted_position,
   output logic [gas_pkg::TIME_W-1:0]  rsp_chosen_start,
   output logic [gas_pkg::TIME_W-1:0]  rsp_chosen_finish,
   output logic [gas_pkg::OUT_W-1:0]   rsp_chosen_count,
   output logic                        rsp_overflowed,
   output logic                        rsp_last_pick
);

   gas_pkg::cmd_type    cmd;
   gas_pkg::status_type status;

   // sequencer: load, sort passes, greedy pass, final flush
   gas_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_is_last),
      .status      (status),
      .cmd         (cmd),
      .req_stall   (req_stall)
   );

   // memory, sort registers, held pick and response register
   gas_dpath #(
      .MAX_ACTIVITIES (MAX_ACTIVITIES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_start_time      (req_start_time),
      .req_finish_time     (req_finish_time),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sorted_position (rsp_sorted_position),
      .rsp_chosen_start    (rsp_chosen_start),
      .rsp_chosen_finish   (rsp_chosen_finish),
      .rsp_chosen_count    (rsp_chosen_count),
      .rsp_overflowed      (rsp_overflowed),
      .rsp_last_pick       (rsp_last_pick)
   );

endmodule

/* rtl/gas_ctrl.sv */
// Controller state machine of the activity selection core.
module gas_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_is_last,
   input  gas_pkg::status_type status,
   output gas_pkg::cmd_type    cmd,
   output logic                req_stall
);

   gas_pkg::state_type state_ff;
   gas_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gas_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gas_pkg::ST_LOAD: begin
            if (req_valid && req_is_last) state_in = gas_pkg::ST_SORT_CHK;
         end
         gas_pkg::ST_SORT_CHK: begin
            state_in = status.more_sort ? gas_pkg::ST_SORT_RD : gas_pkg::ST_PICK_RD;
         end
         gas_pkg::ST_SORT_RD:  state_in = gas_pkg::ST_SORT_CAP;
         gas_pkg::ST_SORT_CAP: state_in = gas_pkg::ST_SCAN;
         gas_pkg::ST_SCAN: begin
            if (status.scan_done) state_in = gas_pkg::ST_SWAP_A;
         end
         gas_pkg::ST_SWAP_A:   state_in = gas_pkg::ST_SWAP_B;
         gas_pkg::ST_SWAP_B:   state_in = gas_pkg::ST_SORT_CHK;
         gas_pkg::ST_PICK_RD:  state_in = gas_pkg::ST_PICK_CHK;
         gas_pkg::ST_PICK_CHK: begin
            if (!status.qualifies || !status.pend_valid || status.out_free) begin
               state_in = status.last_j ? gas_pkg::ST_FLUSH : gas_pkg::ST_PICK_RD;
            end
         end
         gas_pkg::ST_FLUSH: begin
            if (status.out_free) state_in = gas_pkg::ST_LOAD;
         end
         default: state_in = gas_pkg::ST_LOAD;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         gas_pkg::ST_LOAD: begin
            req_stall     = 1'b0;
            cmd.load      = req_valid;
            cmd.sort_init = req_valid && req_is_last;
         end
         gas_pkg::ST_SORT_CHK: cmd.pick_init = !status.more_sort;
         gas_pkg::ST_SORT_RD:  cmd.sort_rd   = 1'b1;
         gas_pkg::ST_SORT_CAP: cmd.sort_cap  = 1'b1;
         gas_pkg::ST_SCAN:     cmd.scan_step = 1'b1;
         gas_pkg::ST_SWAP_A:   cmd.swap_a    = 1'b1;
         gas_pkg::ST_SWAP_B:   cmd.swap_b    = 1'b1;
         gas_pkg::ST_PICK_RD:  cmd.pick_rd   = 1'b1;
         gas_pkg::ST_PICK_CHK: begin
            cmd.pick_skip = !status.qualifies;
            cmd.pick_take = status.qualifies && (!status.pend_valid || status.out_free);
         end
         gas_pkg::ST_FLUSH: begin
            cmd.flush     = status.out_free;
            cmd.clear_set = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* rtl/gas_dpath.sv */
// Datapath of the activity selection core: activity memory, sort and pick registers, output.
module gas_dpath #(
   parameter int MAX_ACTIVITIES = gas_pkg::MAX_ACTIVITIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gas_pkg::cmd_type            cmd,
   output gas_pkg::status_type         status,
   input  logic [gas_pkg::TIME_W-1:0]  req_start_time,
   input  logic [gas_pkg::TIME_W-1:0]  req_finish_time,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [gas_pkg::OUT_W-1:0]   rsp_sorted_position,
   output logic [gas_pkg::TIME_W-1:0]  rsp_chosen_start,
   output logic [gas_pkg::TIME_W-1:0]  rsp_chosen_finish,
   output logic [gas_pkg::OUT_W-1:0]   rsp_chosen_count,
   output logic                        rsp_overflowed,
   output logic                        rsp_last_pick
);

   localparam int IDX_W = $clog2(MAX_ACTIVITIES);
   localparam int CNT_W = $clog2(MAX_ACTIVITIES + 1);

   gas_pkg::entry_type mem [MAX_ACTIVITIES];
   gas_pkg::entry_type rd_data_ff;

   logic [CNT_W-1:0] loaded_ff, loaded_in;
   logic             overflow_ff, overflow_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0] best_idx_ff, best_idx_in;
   gas_pkg::entry_type best_ff, best_in;
   gas_pkg::entry_type pos_entry_ff, pos_entry_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] picks_ff, picks_in;
   logic [gas_pkg::TIME_W-1:0] last_fin_ff, last_fin_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [CNT_W-1:0] pend_pos_ff, pend_pos_in;
   logic [CNT_W-1:0] pend_cnt_ff, pend_cnt_in;
   gas_pkg::entry_type pend_ff, pend_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [gas_pkg::OUT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [gas_pkg::OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   gas_pkg::entry_type rsp_ff, rsp_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             has_room;
   logic             scan_more;
   logic             out_free;
   logic             push;
   logic             we;
   logic [IDX_W-1:0] wr_addr;
   gas_pkg::entry_type wr_data;
   logic             re;
   logic [IDX_W-1:0] rd_addr;
   logic [CNT_W+gas_pkg::OUT_W-1:0] pend_pos_wide;
   logic [CNT_W+gas_pkg::OUT_W-1:0] pend_cnt_wide;

   assign has_room  = loaded_ff < CNT_W'(MAX_ACTIVITIES);
   assign scan_more = scan_ff < loaded_ff;
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign push      = (cmd.pick_take && pend_vld_ff) || cmd.flush;

   assign status.more_sort  = ({1'b0, pos_ff} + 1'b1) < {1'b0, loaded_ff};
   assign status.scan_done  = !scan_more && !rd_vld_ff;
   assign status.qualifies  = (j_ff == '0) || (rd_data_ff.start_time >= last_fin_ff);
   assign status.pend_valid = pend_vld_ff;
   assign status.out_free   = out_free;
   assign status.last_j     = ({1'b0, j_ff} + 1'b1) == {1'b0, loaded_ff};

   // memory port selection
   always_comb begin
      we      = 1'b0;
      wr_addr = loaded_ff[IDX_W-1:0];
      wr_data = {req_start_time, req_finish_time};
      if (cmd.load && has_room) begin
         we = 1'b1;
      end else if (cmd.swap_a) begin
         we      = 1'b1;
         wr_addr = pos_ff[IDX_W-1:0];
         wr_data = best_ff;
      end else if (cmd.swap_b) begin
         we      = 1'b1;
         wr_addr = best_idx_ff[IDX_W-1:0];
         wr_data = pos_entry_ff;
      end
      re      = 1'b0;
      rd_addr = pos_ff[IDX_W-1:0];
      if (cmd.sort_rd) begin
         re = 1'b1;
      end else if (cmd.scan_step && scan_more) begin
         re      = 1'b1;
         rd_addr = scan_ff[IDX_W-1:0];
      end else if (cmd.pick_rd) begin
         re      = 1'b1;
         rd_addr = j_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      if (re) rd_data_ff <= mem[rd_addr];
   end

   assign pend_pos_wide = {{gas_pkg::OUT_W{1'b0}}, pend_pos_ff};
   assign pend_cnt_wide = {{gas_pkg::OUT_W{1'b0}}, pend_cnt_ff};

   always_comb begin
      loaded_in    = loaded_ff;
      overflow_in  = overflow_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = rd_vld_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      pos_entry_in = pos_entry_ff;
      j_in         = j_ff;
      picks_in     = picks_ff;
      last_fin_in  = last_fin_ff;
      pend_vld_in  = pend_vld_ff;
      pend_pos_in  = pend_pos_ff;
      pend_cnt_in  = pend_cnt_ff;
      pend_in      = pend_ff;
      rsp_vld_in   = rsp_vld_ff && rsp_stall;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load) begin
         if (has_room) loaded_in = loaded_ff + 1'b1;
         else          overflow_in = 1'b1;
      end
      if (cmd.sort_init) pos_in = '0;

      if (cmd.sort_cap) begin
         pos_entry_in = rd_data_ff;
         best_in      = rd_data_ff;
         best_idx_in  = pos_ff;
         scan_in      = pos_ff + 1'b1;
         rd_vld_in    = 1'b0;
      end

      if (cmd.scan_step) begin
         rd_vld_in = scan_more;
         if (scan_more) begin
            rd_idx_in = scan_ff;
            scan_in   = scan_ff + 1'b1;
         end
         // strict compare keeps the first minimum
         if (rd_vld_ff && (rd_data_ff.finish_time < best_ff.finish_time)) begin
            best_in     = rd_data_ff;
            best_idx_in = rd_idx_ff;
         end
      end

      if (cmd.swap_b) pos_in = pos_ff + 1'b1;

      if (cmd.pick_init) begin
         j_in        = '0;
         picks_in    = '0;
         pend_vld_in = 1'b0;
      end
      if (cmd.pick_skip) j_in = j_ff + 1'b1;

      if (push) begin
         rsp_vld_in  = 1'b1;
         rsp_pos_in  = pend_pos_wide[gas_pkg::OUT_W-1:0];
         rsp_cnt_in  = pend_cnt_wide[gas_pkg::OUT_W-1:0];
         rsp_in      = pend_ff;
         rsp_ovf_in  = overflow_ff;
         rsp_last_in = cmd.flush;
      end

      if (cmd.pick_take) begin
         pend_vld_in = 1'b1;
         pend_pos_in = j_ff + 1'b1;
         pend_cnt_in = picks_ff + 1'b1;
         pend_in     = rd_data_ff;
         picks_in    = picks_ff + 1'b1;
         last_fin_in = rd_data_ff.finish_time;
         j_in        = j_ff + 1'b1;
      end

      if (cmd.flush) pend_vld_in = 1'b0;

      if (cmd.clear_set) begin
         loaded_in   = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= '0;
         overflow_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         loaded_ff   <= loaded_in;
         overflow_ff <= overflow_in;
         rd_vld_ff   <= rd_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      pos_entry_ff <= pos_entry_in;
      j_ff         <= j_in;
      picks_ff     <= picks_in;
      last_fin_ff  <= last_fin_in;
      pend_pos_ff  <= pend_pos_in;
      pend_cnt_ff  <= pend_cnt_in;
      pend_ff      <= pend_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_ff       <= rsp_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_sorted_position = rsp_pos_ff;
   assign rsp_chosen_start    = rsp_ff.start_time;
   assign rsp_chosen_finish   = rsp_ff.finish_time;
   assign rsp_chosen_count    = rsp_cnt_ff;
   assign rsp_overflowed      = rsp_ovf_ff;
   assign rsp_last_pick       = rsp_last_ff;

endmodule

/* tb/greedy_activity_selection_core_tb.sv */
// Self-checking testbench of the greedy activity selection core.
`timescale 1ns / 1ps

module greedy_activity_selection_core_tb;

   localparam int TIME_W       = gas_pkg::TIME_W;
   localparam int OUT_W        = gas_pkg::OUT_W;
   localparam int CAPACITY     = gas_pkg::MAX_ACTIVITIES_DEF;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 100;
   localparam int PRINT_CAP    = 100;

   // One response beat: a chosen activity.
   typedef struct packed {
      logic [OUT_W-1:0]  position;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] finish_time;
      logic [OUT_W-1:0]  count;
      logic              overflowed;
      logic              last_pick;
   } pick_type;

   // One directed request row; typed rows carry their single pick.
   typedef struct {
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] finish_time;
      logic              is_last;
      bit                typed;
      pick_type          pick;
   } row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [TIME_W-1:0] req_start_time;
   logic [TIME_W-1:0] req_finish_time;
   logic              req_is_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [OUT_W-1:0]  rsp_sorted_position;
   logic [TIME_W-1:0] rsp_chosen_start;
   logic [TIME_W-1:0] rsp_chosen_finish;
   logic [OUT_W-1:0]  rsp_chosen_count;
   logic              rsp_overflowed;
   logic              rsp_last_pick;

   greedy_activity_selection_core #(
      .MAX_ACTIVITIES(CAPACITY)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_start_time      (req_start_time),
      .req_finish_time     (req_finish_time),
      .req_is_last         (req_is_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sorted_position (rsp_sorted_position),
      .rsp_chosen_start    (rsp_chosen_start),
      .rsp_chosen_finish   (rsp_chosen_finish),
      .rsp_chosen_count    (rsp_chosen_count),
      .rsp_overflowed      (rsp_overflowed),
      .rsp_last_pick       (rsp_last_pick)
   );

   // Shadow copy of the activity store, the set count and the drop flag.
   logic [TIME_W-1:0] shadow_start[CAPACITY];
   logic [TIME_W-1:0] shadow_finish[CAPACITY];
   int                shadow_loaded;
   bit                shadow_dropped;

   pick_type          expected_picks[$];

   int err_count;
   int beats_sent;
   int sets_closed;
   int sets_dropped;
   int picks_checked;
   int cycle_count;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint want, input longint got);
      if (err_count < PRINT_CAP)
         $display("ERROR t=%0t pick %0d: %s expected %0h got %0h",
                  $realtime, picks_checked, what, want, got);
      err_count++;
   endtask

   // Store one accepted activity; on the closing beat, sort by finish with a
   // first-strict-minimum selection sort, then pick greedily. The picks are
   // queued only when keep_picks is set (typed rows queue their own).
   task automatic predict_selection(input logic [TIME_W-1:0] st,
                                    input logic [TIME_W-1:0] fin,
                                    input logic last_flag, input bit keep_picks);
      int                n;
      int                pos;
      int                scan;
      int                best;
      int                prev;
      int                picks;
      logic [TIME_W-1:0] tmp;
      pick_type          p;
      pick_type          held;
      if (shadow_loaded < CAPACITY) begin
         shadow_start[shadow_loaded]  = st;
         shadow_finish[shadow_loaded] = fin;
         shadow_loaded++;
      end else begin
         shadow_dropped = 1'b1;
      end
      if (!last_flag) return;

      n = shadow_loaded;
      for (pos = 0; pos + 1 < n; pos++) begin
         best = pos;
         for (scan = pos + 1; scan < n; scan++)
            if (shadow_finish[scan] < shadow_finish[best]) best = scan;
         if (best != pos) begin
            tmp = shadow_finish[best];
            shadow_finish[best] = shadow_finish[pos];
            shadow_finish[pos] = tmp;
            tmp = shadow_start[best];
            shadow_start[best] = shadow_start[pos];
            shadow_start[pos] = tmp;
         end
      end

      // Hold each pick until the next one shows up, so the last gets its flag.
      prev  = 0;
      picks = 1;
      held  = '{position: OUT_W'(1), start_time: shadow_start[0],
                finish_time: shadow_finish[0], count: OUT_W'(1),
                overflowed: shadow_dropped, last_pick: 1'b0};
      for (scan = 1; scan < n; scan++) begin
         if (shadow_start[scan] >= shadow_finish[prev]) begin
            if (keep_picks) expected_picks.push_back(held);
            picks++;
            prev = scan;
            p = '{position: OUT_W'(scan + 1), start_time: shadow_start[scan],
                  finish_time: shadow_finish[scan], count: OUT_W'(picks),
                  overflowed: shadow_dropped, last_pick: 1'b0};
            held = p;
         end
      end
      held.last_pick = 1'b1;
      if (keep_picks) expected_picks.push_back(held);

      sets_closed++;
      if (shadow_dropped) sets_dropped++;
      shadow_loaded  = 0;
      shadow_dropped = 1'b0;
   endtask

   // Drive one request beat at the falling edge, after a burst gap if one is
   // due, and hold it until the core takes it at a rising edge.
   task automatic send_beat(input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] fin,
                            input logic last_flag, input bit keep_picks);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_start_time  <= st;
      req_finish_time <= fin;
      req_is_last     <= last_flag;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      predict_selection(st, fin, last_flag, keep_picks);
   endtask

   // Response side: compare every accepted beat with the oldest expected pick.
   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_picks.size() == 0) begin
            report_mismatch("unexpected response beat", 0, 1);
         end else begin
            want = expected_picks.pop_front();
            if (rsp_sorted_position !== want.position)
               report_mismatch("sorted_position", want.position, rsp_sorted_position);
            if (rsp_chosen_start !== want.start_time)
               report_mismatch("chosen_start", want.start_time, rsp_chosen_start);
            if (rsp_chosen_finish !== want.finish_time)
               report_mismatch("chosen_finish", want.finish_time, rsp_chosen_finish);
            if (rsp_chosen_count !== want.count)
               report_mismatch("chosen_count", want.count, rsp_chosen_count);
            if (rsp_overflowed !== want.overflowed)
               report_mismatch("overflowed", want.overflowed, rsp_overflowed);
            if (rsp_last_pick !== want.last_pick)
               report_mismatch("last_pick", want.last_pick, rsp_last_pick);
         end
         picks_checked++;
      end
   end

   // Response stall: switch at random among free-running, random, long-run and
   // alternating patterns.
   initial begin
      int mode;
      int mode_left;
      int run_left;
      bit stall_now;
      rsp_stall = 1'b0;
      mode      = 0;
      mode_left = 0;
      run_left  = 0;
      stall_now = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         case (mode)
            0: stall_now = 1'b0;
            1: stall_now = ($urandom_range(0, 2) == 0);
            2: begin
               if (run_left == 0) begin
                  stall_now = ~stall_now;
                  run_left  = $urandom_range(1, 8);
               end
               run_left--;
            end
            default: stall_now = ~stall_now;
         endcase
         rsp_stall <= stall_now;
      end
   end

   // Watchdog: end the run if it outlives any correct schedule.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d picks outstanding",
               cycle_count, expected_picks.size());
      $display("FAIL");
      $finish;
   end

   // Random time in one of three shapes: full range, short overlapping
   // intervals, or the field extremes mixed with random values.
   function automatic logic [TIME_W-1:0] pick_time(input int shape, input logic [TIME_W-1:0] base);
      case (shape)
         0: return TIME_W'($urandom);
         1: return base + TIME_W'($urandom_range(0, 15));
         default: begin
            case ($urandom_range(0, 2))
               0: return '0;
               1: return '1;
               default: return TIME_W'($urandom);
            endcase
         end
      endcase
   endfunction

   row_type directed_rows[$];

   initial begin
      row_type           row;
      int                set_size;
      int                set_index;
      int                shape;
      int                k;
      logic [TIME_W-1:0] st;
      logic [TIME_W-1:0] fin;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_start_time  = '0;
      req_finish_time = '0;
      req_is_last     = 1'b0;
      err_count       = 0;
      beats_sent      = 0;
      sets_closed     = 0;
      sets_dropped    = 0;
      picks_checked   = 0;
      burst_left      = 0;
      shadow_loaded   = 0;
      shadow_dropped  = 1'b0;

      // Single-activity sets: the one entry is always the only pick.
      directed_rows = '{
         '{16'h0000, 16'h0000, 1'b1, 1'b1, '{6'd1, 16'h0000, 16'h0000, 6'd1, 1'b0, 1'b1}},
         '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{6'd1, 16'hFFFF, 16'hFFFF, 6'd1, 1'b0, 1'b1}},
         '{16'hFFFF, 16'h0000, 1'b1, 1'b1, '{6'd1, 16'hFFFF, 16'h0000, 6'd1, 1'b0, 1'b1}},
         // classic textbook set
         '{16'd1, 16'd4, 1'b0, 1'b0, '0},
         '{16'd3, 16'd5, 1'b0, 1'b0, '0},
         '{16'd0, 16'd6, 1'b0, 1'b0, '0},
         '{16'd5, 16'd7, 1'b1, 1'b0, '0},
         // equal finishes: the swap reorders ties
         '{16'd9, 16'd5, 1'b0, 1'b0, '0},
         '{16'd1, 16'd5, 1'b0, 1'b0, '0},
         '{16'd2, 16'd3, 1'b0, 1'b0, '0},
         '{16'd4, 16'd5, 1'b1, 1'b0, '0},
         // finishes in falling order
         '{16'h0000, 16'hFFFF, 1'b0, 1'b0, '0},
         '{16'h0000, 16'h8000, 1'b0, 1'b0, '0},
         '{16'h0000, 16'h0001, 1'b1, 1'b0, '0},
         // start equal to the previous finish still qualifies
         '{16'd0,  16'd10, 1'b0, 1'b0, '0},
         '{16'd10, 16'd20, 1'b0, 1'b0, '0},
         '{16'd20, 16'd20, 1'b1, 1'b0, '0},
         // every activity overlaps the first
         '{16'd0,  16'd100, 1'b0, 1'b0, '0},
         '{16'd50, 16'd100, 1'b1, 1'b0, '0},
         // extremes mixed in one set
         '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
         '{16'h0000, 16'h0000, 1'b0, 1'b0, '0},
         '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_beat(row.start_time, row.finish_time, row.is_last, !row.typed);
         if (row.typed) expected_picks.push_back(row.pick);
      end

      // Random sets. The first two overrun the store, the closing beat
      // included; after that most sets are small and a few run past capacity.
      set_index = 0;
      while (beats_sent < 210) begin
         if (set_index == 0)      set_size = CAPACITY + 1;
         else if (set_index == 1) set_size = CAPACITY + 4;
         else begin
            k = $urandom_range(0, 19);
            if (k < 14)      set_size = $urandom_range(1, 6);
            else if (k < 18) set_size = $urandom_range(7, 16);
            else             set_size = $urandom_range(CAPACITY - 2, CAPACITY + 3);
         end
         shape = $urandom_range(0, 2);
         for (k = 0; k < set_size; k++) begin
            st  = (shape == 1) ? TIME_W'($urandom_range(0, 60)) : pick_time(shape, '0);
            fin = pick_time(shape, st);
            send_beat(st, fin, k == set_size - 1, 1'b1);
         end
         set_index++;
      end

      @(negedge clock);
      req_valid <= 1'b0;

      while (expected_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats in %0d sets, %0d of them overran the store.",
               beats_sent, sets_closed, sets_dropped);
      $display("Checked %0d picks with %0d mismatches in %0d cycles.",
               picks_checked, err_count, cycle_count);
      if (err_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* greedy_activity_selection_core.f */
rtl/gas_pkg.sv
rtl/gas_ctrl.sv
rtl/gas_dpath.sv
rtl/greedy_activity_selection_core.sv
tb/greedy_activity_selection_core_tb.sv
